### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCC_ASSERT_IMP(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
      else $error("assertion failed");
// next-cycle implication
`define SCC_ASSERT_NXT(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
      else $error("assertion failed");
`else
`define SCC_ASSERT_IMP(lbl, clk, rst, ant, con)
`define SCC_ASSERT_NXT(lbl, clk, rst, ant, con)
`endif
`endif

### hw/rtl/scc_pkg.sv
// shared types, constants and command byte table of the capture sequencer
`default_nettype none
package scc_pkg;
   localparam int PKT_BYTES = 64;
   localparam int BUF_AW    = $clog2(PKT_BYTES);
   localparam int CNT_W     = BUF_AW + 1;

   // input commands
   localparam logic [1:0] CMD_RX_BYTE = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_SYNC    = 2'd2;
   localparam logic [1:0] CMD_CAPTURE = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_BADPKT   = 2'd2;
   localparam logic [1:0] ST_LENGTH   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_CAM_ADDR = 2'd0;
   localparam logic [1:0] REG_PIC_FMT  = 2'd1;
   localparam logic [1:0] REG_SYNC_TO  = 2'd2;

   // protocol phases; the phase codes double as command codes for the sender
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_SYNC_ACK = 4'd1;
   localparam logic [3:0] PH_SYNC_SYN = 4'd2;
   localparam logic [3:0] PH_INIT     = 4'd3;
   localparam logic [3:0] PH_PSIZE    = 4'd4;
   localparam logic [3:0] PH_SNAP     = 4'd5;
   localparam logic [3:0] PH_GETPIC   = 4'd6;
   localparam logic [3:0] PH_DATA     = 4'd7;
   localparam logic [3:0] PH_PKT      = 4'd8;
   localparam logic [3:0] TX_SYNCDONE = 4'd9;
   localparam logic [3:0] TX_FINAL    = 4'd10;
   localparam logic [3:0] TX_STATUS   = 4'd11;

   localparam logic [7:0] B_SOF      = 8'haa;
   localparam logic [7:0] ID_SYNC    = 8'h0d;
   localparam logic [7:0] ID_ACK     = 8'h0e;
   localparam logic [7:0] ID_DATA    = 8'h0a;
   localparam logic [7:0] ID_INIT    = 8'h01;
   localparam logic [7:0] ID_GETPIC  = 8'h04;
   localparam logic [7:0] ID_SNAP    = 8'h05;
   localparam logic [7:0] ID_PSIZE   = 8'h06;
   localparam logic [7:0] B_END      = 8'hf0;
   localparam logic [7:0] B_INIT_SUB = 8'h07;
   localparam logic [7:0] B_PSIZE_SB = 8'h08;
   localparam logic [7:0] B_PSIZE_LO = 8'(PKT_BYTES % 256);
   localparam logic [7:0] B_PSIZE_HI = 8'(PKT_BYTES / 256);

   localparam logic [15:0] INIT_LIMIT_MS = 16'd3000;
   localparam logic [10:0] IDLE_LIMIT_MS = 11'd500;
   localparam logic [10:0] DATA_LIMIT_MS = 11'd1000;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
   } buf_rd_req_type;

   typedef struct packed {
      logic              vld;
      logic [BUF_AW-1:0] idx;
      logic [7:0]        data;
   } buf_rd_rsp_type;

   // one byte of a six-byte command
   function automatic logic [7:0] cmd_byte(input logic [3:0] code, input logic [2:0] idx,
                                           input logic [7:0] cam, input logic [7:0] fmt,
                                           input logic [15:0] pidx);
      logic [7:0] b [0:5];
      b[0] = B_SOF;
      b[1] = ID_ACK | cam;
      b[2] = 8'h00;
      b[3] = 8'h00;
      b[4] = 8'h00;
      b[5] = 8'h00;
      case (code)
         PH_SYNC_ACK: b[1] = ID_SYNC | cam;
         PH_INIT: begin
            b[1] = ID_INIT | cam;
            b[3] = B_INIT_SUB;
            b[5] = fmt;
         end
         PH_PSIZE: begin
            b[1] = ID_PSIZE | cam;
            b[2] = B_PSIZE_SB;
            b[3] = B_PSIZE_LO;
            b[4] = B_PSIZE_HI;
         end
         PH_SNAP: b[1] = ID_SNAP | cam;
         PH_GETPIC: begin
            b[1] = ID_GETPIC | cam;
            b[2] = 8'h01;
         end
         PH_PKT: begin
            b[4] = pidx[7:0];
            b[5] = pidx[15:8];
         end
         TX_SYNCDONE: b[2] = ID_SYNC;
         TX_FINAL: begin
            b[4] = B_END;
            b[5] = B_END;
         end
         default: b[0] = B_SOF;
      endcase
      if (idx > 3'd5) return 8'h00;
      return b[idx];
   endfunction
endpackage
`default_nettype wire

### hw/rtl/scc_if.sv
// handshake channel interfaces of the capture sequencer
`default_nettype none
interface scc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   modport source (output valid, cmd, rx_byte, input ready);
   modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface scc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       finished;
   logic [1:0] status;
   logic       last;
   modport source (output valid, kind, data_byte, finished, status, last, input ready);
   modport sink (input valid, kind, data_byte, finished, status, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/scc_pkt_buf.sv
// packet buffer memory with one write port and a registered read port
`default_nettype none
module scc_pkt_buf (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [scc_pkg::BUF_AW-1:0]  wr_addr,
   input  wire logic [7:0]                  wr_data,
   input  wire scc_pkg::buf_rd_req_type     rd_req,
   output      scc_pkg::buf_rd_rsp_type     rd_rsp
);
   logic [7:0]                mem [0:scc_pkg::PKT_BYTES-1];
   logic [7:0]                rd_data_ff;
   logic [scc_pkg::BUF_AW-1:0] rd_idx_ff;
   logic                      rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
         rd_idx_ff  <= rd_req.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_req.en;
      end
   end

   assign rd_rsp.vld  = rd_vld_ff;
   assign rd_rsp.idx  = rd_idx_ff;
   assign rd_rsp.data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/serial_camera_capture_sequencer.sv
// top level of the serial camera capture sequencer
`default_nettype none
`include "assert_macros.svh"
// host side of a six-byte command uart camera protocol. each req beat is a received
// byte, a 1 ms tick, a start-sync or a start-capture; each rsp beat is one byte to
// transmit, one image payload byte or a status-only report, with last marking the final
// beat caused by a req beat and finished/status on the beat that completes a started
// operation. the block takes one req beat at a time: a beat that causes nothing leaves
// the block waiting, a command is sent byte by byte, a reply check reads the six stored
// reply bytes back from the packet buffer, and a finished packet gets a checksum pass
// and then a payload pass that reads each payload byte before it is emitted, since
// every pass goes through the single read port of the buffer.
// rsp stalls only hold the sequencer; the buffer needs no clearing after reset.
module serial_camera_capture_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   scc_req_if.sink          req_ch,
   scc_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   localparam int AW = scc_pkg::BUF_AW;
   localparam int CW = scc_pkg::CNT_W;

   // sequencer states
   localparam logic [3:0] S_WAIT = 4'd0;
   localparam logic [3:0] S_SEND = 4'd1;
   localparam logic [3:0] S_RCHK = 4'd2;
   localparam logic [3:0] S_RDEC = 4'd3;
   localparam logic [3:0] S_FIN  = 4'd4;
   localparam logic [3:0] S_SUM  = 4'd5;
   localparam logic [3:0] S_SCHK = 4'd6;
   localparam logic [3:0] S_PRD  = 4'd7;
   localparam logic [3:0] S_PEM  = 4'd8;
   localparam logic [3:0] S_PEND = 4'd9;

   // decided actions
   localparam logic [2:0] A_NONE   = 3'd0;
   localparam logic [2:0] A_ISSUE  = 3'd1;
   localparam logic [2:0] A_STATUS = 3'd2;
   localparam logic [2:0] A_FINAL  = 3'd3;
   localparam logic [2:0] A_SDONE  = 3'd4;
   localparam logic [2:0] A_PKTFIN = 3'd5;
   localparam logic [2:0] A_NEXT   = 3'd6;

   // configuration registers
   logic [7:0]  cam_ff, cam_in;
   logic [7:0]  fmt_ff, fmt_in;
   logic [15:0] sto_ff, sto_in;

   // control state
   logic [3:0]  state_ff, state_in;
   logic [3:0]  phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [10:0] idle_ff, idle_in;
   logic [15:0] pt_ff, pt_in;
   logic [23:0] exp_ff, exp_in;
   logic [24:0] recv_ff, recv_in;
   logic [15:0] pidx_ff, pidx_in;
   logic [7:0]  sum_ff, sum_in;
   logic        sum_ok_ff, sum_ok_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [3:0]  code_ff, code_in;
   logic [2:0]  sidx_ff, sidx_in;
   logic        sfin_ff, sfin_in;
   logic [1:0]  sst_ff, sst_in;
   logic [7:0]  rep_ff [0:5];
   logic [7:0]  rep_in [0:5];

   // output register
   logic        rv_ff, rv_in;
   logic [1:0]  rkind_ff, rkind_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic        rfin_ff, rfin_in;
   logic [1:0]  rst_ff, rst_in;
   logic        rlast_ff, rlast_in;

   logic        out_free;
   logic        req_acc;
   logic        wr_en;
   scc_pkg::buf_rd_req_type rd_req;
   scc_pkg::buf_rd_rsp_type rd_rsp;
   logic [AW-1:0] cnt_m2;

   assign out_free = !rv_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_WAIT);
   assign req_acc = req_ch.valid && req_ch.ready;
   assign cnt_m2 = AW'(cnt_ff - CW'(2));

   scc_pkt_buf u_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_ch.rx_byte),
      .rd_req  (rd_req),
      .rd_rsp  (rd_rsp)
   );

   // configuration port
   assign pready = 1'b1;
   always_comb begin
      cam_in = cam_ff;
      fmt_in = fmt_ff;
      sto_in = sto_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            scc_pkg::REG_CAM_ADDR: cam_in = pwdata[7:0];
            scc_pkg::REG_PIC_FMT:  fmt_in = pwdata[7:0];
            scc_pkg::REG_SYNC_TO:  sto_in = pwdata[15:0];
            default: cam_in = cam_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         scc_pkg::REG_CAM_ADDR: prdata = {24'd0, cam_ff};
         scc_pkg::REG_PIC_FMT:  prdata = {24'd0, fmt_ff};
         scc_pkg::REG_SYNC_TO:  prdata = {16'd0, sto_ff};
         default:               prdata = 32'd0;
      endcase
   end

   // sequencer
   always_comb begin
      logic [2:0]  act;
      logic [3:0]  act_ph;
      logic [1:0]  act_st;
      logic        do_retry;
      logic [15:0] rpt;
      logic [CW-1:0] cnt_nx;
      logic [10:0] lim;
      logic        ok_ack;
      logic [7:0]  ack_id;
      logic [24:0] recv_nx;

      state_in  = state_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      idle_in   = idle_ff;
      pt_in     = pt_ff;
      exp_in    = exp_ff;
      recv_in   = recv_ff;
      pidx_in   = pidx_ff;
      sum_in    = sum_ff;
      sum_ok_in = sum_ok_ff;
      ptr_in    = ptr_ff;
      code_in   = code_ff;
      sidx_in   = sidx_ff;
      sfin_in   = sfin_ff;
      sst_in    = sst_ff;
      for (int i = 0; i < 6; i++) rep_in[i] = rep_ff[i];
      wr_en       = 1'b0;
      rd_req.en   = 1'b0;
      rd_req.addr = ptr_ff[AW-1:0];
      rv_in    = rv_ff && !rsp_ch.ready;
      rkind_in = rkind_ff;
      rdata_in = rdata_ff;
      rfin_in  = rfin_ff;
      rst_in   = rst_ff;
      rlast_in = rlast_ff;
      act      = A_NONE;
      act_ph   = scc_pkg::PH_IDLE;
      act_st   = scc_pkg::ST_OK;
      do_retry = 1'b0;
      rpt      = pt_ff;
      cnt_nx   = cnt_ff + CW'(1);
      lim      = (phase_ff == scc_pkg::PH_DATA) ? scc_pkg::DATA_LIMIT_MS
                                                : scc_pkg::IDLE_LIMIT_MS;
      recv_nx  = recv_ff + 25'(cnt_ff) - 25'd6;
      unique case (phase_ff)
         scc_pkg::PH_INIT:   ack_id = scc_pkg::ID_INIT;
         scc_pkg::PH_PSIZE:  ack_id = scc_pkg::ID_PSIZE;
         scc_pkg::PH_SNAP:   ack_id = scc_pkg::ID_SNAP;
         scc_pkg::PH_GETPIC: ack_id = scc_pkg::ID_GETPIC;
         default:            ack_id = scc_pkg::ID_SYNC;
      endcase
      ok_ack = rep_ff[0] == scc_pkg::B_SOF && rep_ff[1] == (scc_pkg::ID_ACK | cam_ff) &&
               rep_ff[2] == ack_id && rep_ff[4] == 8'h00 && rep_ff[5] == 8'h00;

      unique case (state_ff)
         S_WAIT: begin
            if (req_acc) begin
               unique case (req_ch.cmd)
                  scc_pkg::CMD_SYNC: begin
                     pt_in = 16'd0;
                     if (sto_ff == 16'd0) begin
                        act = A_STATUS;
                     end else begin
                        act    = A_ISSUE;
                        act_ph = scc_pkg::PH_SYNC_ACK;
                     end
                  end
                  scc_pkg::CMD_CAPTURE: begin
                     pt_in   = 16'd0;
                     exp_in  = 24'd0;
                     recv_in = 25'd0;
                     pidx_in = 16'd0;
                     act     = A_ISSUE;
                     act_ph  = scc_pkg::PH_INIT;
                  end
                  scc_pkg::CMD_TICK: begin
                     if (phase_ff != scc_pkg::PH_IDLE) begin
                        if (pt_ff != 16'hffff) pt_in = pt_ff + 16'd1;
                        if (idle_ff != 11'h7ff) idle_in = idle_ff + 11'd1;
                        rpt = pt_in;
                        if (idle_in > lim) do_retry = 1'b1;
                     end
                  end
                  default: begin
                     // received byte: stored while a reply or packet is awaited
                     if (phase_ff != scc_pkg::PH_IDLE && cnt_ff < CW'(scc_pkg::PKT_BYTES)) begin
                        wr_en   = 1'b1;
                        cnt_in  = cnt_nx;
                        idle_in = 11'd0;
                        if (phase_ff == scc_pkg::PH_PKT) begin
                           if (cnt_nx >= CW'(scc_pkg::PKT_BYTES)) act = A_PKTFIN;
                        end else if (cnt_nx >= CW'(6)) begin
                           state_in = S_RCHK;
                           ptr_in   = '0;
                        end
                     end
                  end
               endcase
            end
         end
         S_SEND: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rlast_in = (code_ff == scc_pkg::TX_STATUS) || (sidx_ff == 3'd5);
               rfin_in  = sfin_ff && rlast_in;
               rst_in   = rfin_in ? sst_ff : scc_pkg::ST_OK;
               if (code_ff == scc_pkg::TX_STATUS) begin
                  rkind_in = scc_pkg::KIND_STATUS;
                  rdata_in = 8'h00;
               end else begin
                  rkind_in = scc_pkg::KIND_TX;
                  rdata_in = scc_pkg::cmd_byte(code_ff, sidx_ff, cam_ff, fmt_ff, pidx_ff);
               end
               sidx_in = sidx_ff + 3'd1;
               if (rlast_in) state_in = S_WAIT;
            end
         end
         S_RCHK: begin
            // read the six reply bytes back
            rd_req.en = 1'b1;
            ptr_in    = ptr_ff + CW'(1);
            if (rd_rsp.vld) begin
               rep_in[rd_rsp.idx[2:0]] = rd_rsp.data;
               if (rd_rsp.idx == AW'(5)) state_in = S_RDEC;
            end
         end
         S_RDEC: begin
            rpt = pt_ff;
            unique case (phase_ff)
               scc_pkg::PH_SYNC_ACK: begin
                  if (ok_ack) begin
                     act    = A_NEXT;
                     act_ph = scc_pkg::PH_SYNC_SYN;
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               scc_pkg::PH_SYNC_SYN: begin
                  if (rep_ff[0] == scc_pkg::B_SOF && rep_ff[1] == (scc_pkg::ID_SYNC | cam_ff) &&
                      rep_ff[2] == 8'h00 && rep_ff[3] == 8'h00 &&
                      rep_ff[4] == 8'h00 && rep_ff[5] == 8'h00) begin
                     act = A_SDONE;
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               scc_pkg::PH_INIT, scc_pkg::PH_PSIZE, scc_pkg::PH_SNAP: begin
                  if (ok_ack) begin
                     act    = A_ISSUE;
                     act_ph = phase_ff + 4'd1;
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               scc_pkg::PH_GETPIC: begin
                  if (ok_ack) begin
                     act    = A_NEXT;
                     act_ph = scc_pkg::PH_DATA;
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               scc_pkg::PH_DATA: begin
                  if (rep_ff[0] == scc_pkg::B_SOF && rep_ff[1] == (scc_pkg::ID_DATA | cam_ff) &&
                      rep_ff[2] == 8'h01) begin
                     exp_in  = {rep_ff[5], rep_ff[4], rep_ff[3]};
                     recv_in = 25'd0;
                     pidx_in = 16'd0;
                     if (exp_in == 24'd0) begin
                        act = A_FINAL;
                     end else begin
                        act    = A_ISSUE;
                        act_ph = scc_pkg::PH_PKT;
                     end
                  end else begin
                     do_retry = 1'b1;
                  end
               end
               default: state_in = S_WAIT;
            endcase
            if (act == A_NONE && !do_retry) state_in = S_WAIT;
         end
         S_FIN: begin
            // packet closed: too short stops the transfer, else checksum pass
            if (cnt_ff < CW'(6)) begin
               act    = A_FINAL;
               act_st = scc_pkg::ST_BADPKT;
            end else begin
               ptr_in   = '0;
               sum_in   = 8'h00;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            rd_req.en = 1'b1;
            ptr_in    = ptr_ff + CW'(1);
            if (rd_rsp.vld) begin
               if (rd_rsp.idx == cnt_m2) begin
                  sum_ok_in = (sum_ff == rd_rsp.data);
                  state_in  = S_SCHK;
               end else begin
                  sum_in = sum_ff + rd_rsp.data;
               end
            end
         end
         S_SCHK: begin
            if (!sum_ok_ff) begin
               act    = A_FINAL;
               act_st = scc_pkg::ST_BADPKT;
            end else if (cnt_ff == CW'(6)) begin
               state_in = S_PEND;
            end else begin
               ptr_in   = CW'(4);
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            rd_req.en = 1'b1;
            state_in  = S_PEM;
         end
         S_PEM: begin
            // payload bytes never end a beat's results: a command always follows
            if (out_free) begin
               rv_in    = 1'b1;
               rkind_in = scc_pkg::KIND_PAYLOAD;
               rdata_in = rd_rsp.data;
               rfin_in  = 1'b0;
               rst_in   = scc_pkg::ST_OK;
               rlast_in = 1'b0;
               ptr_in   = ptr_ff + CW'(1);
               state_in = (ptr_ff == cnt_ff - CW'(3)) ? S_PEND : S_PRD;
            end
         end
         S_PEND: begin
            recv_in = recv_nx;
            pidx_in = pidx_ff + 16'd1;
            if (recv_nx >= {1'b0, exp_ff}) begin
               act    = A_FINAL;
               act_st = (recv_nx == {1'b0, exp_ff}) ? scc_pkg::ST_OK : scc_pkg::ST_LENGTH;
            end else begin
               act    = A_ISSUE;
               act_ph = scc_pkg::PH_PKT;
            end
         end
         default: state_in = S_WAIT;
      endcase

      // retry of the current step
      if (do_retry) begin
         unique case (phase_ff)
            scc_pkg::PH_SYNC_ACK, scc_pkg::PH_SYNC_SYN: begin
               if (rpt >= sto_ff) begin
                  act = A_STATUS;
               end else begin
                  act    = A_ISSUE;
                  act_ph = scc_pkg::PH_SYNC_ACK;
               end
            end
            scc_pkg::PH_INIT: begin
               act    = A_ISSUE;
               act_ph = (rpt >= scc_pkg::INIT_LIMIT_MS) ? scc_pkg::PH_PSIZE : scc_pkg::PH_INIT;
            end
            scc_pkg::PH_PSIZE, scc_pkg::PH_SNAP: begin
               act    = A_ISSUE;
               act_ph = phase_ff;
            end
            scc_pkg::PH_GETPIC, scc_pkg::PH_DATA: begin
               act    = A_ISSUE;
               act_ph = scc_pkg::PH_GETPIC;
            end
            scc_pkg::PH_PKT: act = A_PKTFIN;
            default: act = A_NONE;
         endcase
      end

      unique case (act)
         A_ISSUE: begin
            phase_in = act_ph;
            cnt_in   = '0;
            idle_in  = 11'd0;
            state_in = S_SEND;
            code_in  = act_ph;
            sidx_in  = 3'd0;
            sfin_in  = 1'b0;
            sst_in   = scc_pkg::ST_OK;
         end
         A_STATUS: begin
            phase_in = scc_pkg::PH_IDLE;
            state_in = S_SEND;
            code_in  = scc_pkg::TX_STATUS;
            sidx_in  = 3'd0;
            sfin_in  = 1'b1;
            sst_in   = scc_pkg::ST_NOTFOUND;
         end
         A_FINAL: begin
            phase_in = scc_pkg::PH_IDLE;
            state_in = S_SEND;
            code_in  = scc_pkg::TX_FINAL;
            sidx_in  = 3'd0;
            sfin_in  = 1'b1;
            sst_in   = act_st;
         end
         A_SDONE: begin
            phase_in = scc_pkg::PH_IDLE;
            state_in = S_SEND;
            code_in  = scc_pkg::TX_SYNCDONE;
            sidx_in  = 3'd0;
            sfin_in  = 1'b1;
            sst_in   = scc_pkg::ST_OK;
         end
         A_PKTFIN: state_in = S_FIN;
         A_NEXT: begin
            phase_in = act_ph;
            cnt_in   = '0;
            idle_in  = 11'd0;
            state_in = S_WAIT;
         end
         default: sst_in = sst_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff   <= 8'd0;
         fmt_ff   <= 8'd5;
         sto_ff   <= 16'd10000;
         state_ff <= S_WAIT;
         phase_ff <= scc_pkg::PH_IDLE;
         cnt_ff   <= '0;
         idle_ff  <= 11'd0;
         pt_ff    <= 16'd0;
         exp_ff   <= 24'd0;
         recv_ff  <= 25'd0;
         pidx_ff  <= 16'd0;
         sum_ff   <= 8'd0;
         rv_ff    <= 1'b0;
      end else begin
         cam_ff   <= cam_in;
         fmt_ff   <= fmt_in;
         sto_ff   <= sto_in;
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         idle_ff  <= idle_in;
         pt_ff    <= pt_in;
         exp_ff   <= exp_in;
         recv_ff  <= recv_in;
         pidx_ff  <= pidx_in;
         sum_ff   <= sum_in;
         rv_ff    <= rv_in;
      end
   end

   // payload and working registers, no reset needed
   always_ff @(posedge clock) begin
      sum_ok_ff <= sum_ok_in;
      ptr_ff    <= ptr_in;
      code_ff   <= code_in;
      sidx_ff   <= sidx_in;
      sfin_ff   <= sfin_in;
      sst_ff    <= sst_in;
      for (int i = 0; i < 6; i++) rep_ff[i] <= rep_in[i];
      rkind_ff  <= rkind_in;
      rdata_ff  <= rdata_in;
      rfin_ff   <= rfin_in;
      rst_ff    <= rst_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_ch.valid     = rv_ff;
   assign rsp_ch.kind      = rkind_ff;
   assign rsp_ch.data_byte = rdata_ff;
   assign rsp_ch.finished  = rfin_ff;
   assign rsp_ch.status    = rst_ff;
   assign rsp_ch.last      = rlast_ff;

   // a status-only beat is always a finished, final, zero-data report
   `SCC_ASSERT_IMP(a_status_shape, clock, reset, rv_ff && rkind_ff == scc_pkg::KIND_STATUS, rdata_ff == 8'h00 && rfin_ff && rlast_ff)
   // payload bytes are always followed by a command
   `SCC_ASSERT_IMP(a_payload_not_last, clock, reset, rv_ff && rkind_ff == scc_pkg::KIND_PAYLOAD, !rlast_ff && !rfin_ff)
   // finished only on the last beat of an input
   `SCC_ASSERT_IMP(a_fin_is_last, clock, reset, rv_ff && rfin_ff, rlast_ff)
   // a byte while idle is dropped without leaving the wait state
   `SCC_ASSERT_NXT(a_idle_drop, clock, reset, req_acc && req_ch.cmd == scc_pkg::CMD_RX_BYTE && phase_ff == scc_pkg::PH_IDLE, state_ff == S_WAIT && phase_ff == scc_pkg::PH_IDLE)
endmodule
`default_nettype wire
